>>> hdl/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types, constants and the byte-position decode table for the
// 16-channel, 11-bit serial bus frame decoder.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam logic [7:0]  StartByte  = 8'h0F;
  localparam logic [4:0]  FrameLen   = 5'd25;
  localparam logic [4:0]  FlagsCount = 5'd24;
  localparam logic [4:0]  SlotFlags  = 5'd16;
  localparam logic [4:0]  SlotEnd    = 5'd17;
  localparam int unsigned MemDepth   = 25;
  localparam int unsigned AddrW      = 5;

  // What a byte count (bytes stored after this byte) produces.
  typedef struct packed {
    logic       emit;       // a result leaves for this byte
    logic       raw;        // result carries the raw byte
    logic       frame_end;  // byte closes the frame
    logic [4:0] slot;       // slot number
    logic [4:0] shamt;      // shift into {cur, prev1, prev2}
  } slot_info_t;

  // Channel k completes on count 2 + ((11k + 10) >> 3); it spans the current
  // byte, the previous one, and the one before that when its bit offset is
  // above five. The shift selects its 11 bits from {cur, prev1, prev2}.
  function automatic slot_info_t decode_count(logic [4:0] c);
    slot_info_t info;
    info = '{emit: 1'b0, raw: 1'b0, frame_end: 1'b0, slot: 5'd0, shamt: 5'd0};
    unique case (c)
      5'd3:    info = '{1'b1, 1'b0, 1'b0, 5'd0,  5'd8};
      5'd4:    info = '{1'b1, 1'b0, 1'b0, 5'd1,  5'd11};
      5'd6:    info = '{1'b1, 1'b0, 1'b0, 5'd2,  5'd6};
      5'd7:    info = '{1'b1, 1'b0, 1'b0, 5'd3,  5'd9};
      5'd8:    info = '{1'b1, 1'b0, 1'b0, 5'd4,  5'd12};
      5'd10:   info = '{1'b1, 1'b0, 1'b0, 5'd5,  5'd7};
      5'd11:   info = '{1'b1, 1'b0, 1'b0, 5'd6,  5'd10};
      5'd12:   info = '{1'b1, 1'b0, 1'b0, 5'd7,  5'd13};
      5'd14:   info = '{1'b1, 1'b0, 1'b0, 5'd8,  5'd8};
      5'd15:   info = '{1'b1, 1'b0, 1'b0, 5'd9,  5'd11};
      5'd17:   info = '{1'b1, 1'b0, 1'b0, 5'd10, 5'd6};
      5'd18:   info = '{1'b1, 1'b0, 1'b0, 5'd11, 5'd9};
      5'd19:   info = '{1'b1, 1'b0, 1'b0, 5'd12, 5'd12};
      5'd21:   info = '{1'b1, 1'b0, 1'b0, 5'd13, 5'd7};
      5'd22:   info = '{1'b1, 1'b0, 1'b0, 5'd14, 5'd10};
      5'd23:   info = '{1'b1, 1'b0, 1'b0, 5'd15, 5'd13};
      5'd24:   info = '{1'b1, 1'b1, 1'b0, SlotFlags, 5'd16};
      5'd25:   info = '{1'b1, 1'b1, 1'b1, SlotEnd,   5'd16};
      default: info = '{emit: 1'b0, raw: 1'b0, frame_end: 1'b0, slot: 5'd0, shamt: 5'd0};
    endcase
    return info;
  endfunction

endpackage

>>> hdl/sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Serial bus frame decoder: 16 packed 11-bit channels, flags and end byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one received byte per
//   request in rx_byte_i. While idle only the start byte 0x0F opens a frame;
//   other bytes are taken and dropped. Inside a frame every byte is stored
//   until 25 bytes have arrived.
//   Output channel (out_valid_o / out_ready_i) carries one result per byte
//   that completes a channel (slots 0..15), the flags byte (slot 16) or the
//   end byte (slot 17, frame_end_o high). flags_clear_o tells whether the
//   most recent flags byte was zero.
//   Each result passes the read stage, then the output register.
//   Throughput: one byte per cycle while in_ready_o is high. The frame store
//   is a 25-entry memory with one write port and two registered read ports;
//   the two previous bytes are read while the current one is written.
//   Reset clears the byte count and the flags status; the frame store is
//   not cleared and needs no clearing pass.
//   When the receiver stalls, the output register holds its result and one
//   more result waits in the read stage; only then does in_ready_o drop.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  slot_o,
  output logic [10:0] slot_value_o,
  output logic        frame_end_o,
  output logic        flags_clear_o
);

  logic [7:0] mem_q [sbd_pkg::MemDepth];

  logic [4:0] count_q, count_d;
  logic       flags_zero_q, flags_zero_d;

  logic                s1_valid_q;
  sbd_pkg::slot_info_t s1_info_q;
  logic [7:0]          s1_byte_q;
  logic [7:0]          s1_prev1_q;
  logic [7:0]          s1_prev2_q;
  logic                s1_fclr_q;

  logic        o_valid_q;
  logic [4:0]  o_slot_q;
  logic [10:0] o_value_q;
  logic        o_end_q;
  logic        o_fclr_q;

  logic                   accept;
  logic                   store;
  logic                   adv_out;
  logic [4:0]             count_inc;
  sbd_pkg::slot_info_t    info;
  logic [sbd_pkg::AddrW-1:0] rd1_addr, rd2_addr;
  logic [23:0]            window;
  logic [10:0]            value;

  assign adv_out    = !o_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv_out;
  assign accept     = in_valid_i && in_ready_o;
  assign store      = accept && ((count_q != 5'd0) || (rx_byte_i == sbd_pkg::StartByte));
  assign count_inc  = count_q + 5'd1;
  assign info       = sbd_pkg::decode_count(count_inc);

  assign rd1_addr = (count_q >= 5'd1) ? count_q - 5'd1 : '0;
  assign rd2_addr = (count_q >= 5'd2) ? count_q - 5'd2 : '0;

  always_comb begin
    count_d      = count_q;
    flags_zero_d = flags_zero_q;
    if (store) begin
      count_d = (count_inc == sbd_pkg::FrameLen) ? 5'd0 : count_inc;
      if (count_inc == sbd_pkg::FlagsCount) begin
        flags_zero_d = (rx_byte_i == 8'h00);
      end
    end
  end

  // Write the current byte, read the two before it.
  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[count_q] <= rx_byte_i;
      s1_prev1_q     <= mem_q[rd1_addr];
      s1_prev2_q     <= mem_q[rd2_addr];
      s1_byte_q      <= rx_byte_i;
      s1_info_q      <= info;
      s1_fclr_q      <= flags_zero_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= 5'd0;
      flags_zero_q <= 1'b1;
      s1_valid_q   <= 1'b0;
      o_valid_q    <= 1'b0;
    end else begin
      count_q      <= count_d;
      flags_zero_q <= flags_zero_d;
      if (in_ready_o) begin
        s1_valid_q <= store && info.emit;
      end
      if (adv_out) begin
        o_valid_q <= s1_valid_q;
      end
    end
  end

  assign window = {s1_byte_q, s1_prev1_q, s1_prev2_q};

  always_comb begin
    if (s1_info_q.raw) begin
      value = {3'b000, s1_byte_q};
    end else begin
      value = 11'(window >> s1_info_q.shamt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && s1_valid_q) begin
      o_slot_q  <= s1_info_q.slot;
      o_value_q <= value;
      o_end_q   <= s1_info_q.frame_end;
      o_fclr_q  <= s1_fclr_q;
    end
  end

  assign out_valid_o   = o_valid_q;
  assign slot_o        = o_slot_q;
  assign slot_value_o  = o_value_q;
  assign frame_end_o   = o_end_q;
  assign flags_clear_o = o_fclr_q;

  // Byte count never reaches the frame length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < sbd_pkg::FrameLen)
    else $error("byte count out of range");

  // Input stalls only with both stages full and the receiver stalling.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && o_valid_q && !out_ready_i))
    else $error("input stalled without backpressure");

  // Read stage holds its result while the output register is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv_out) |=> s1_valid_q)
    else $error("read stage result lost");

  // The end byte always closes the frame and returns the count to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (store && info.frame_end) |=> (count_q == 5'd0))
    else $error("frame not closed on end byte");

endmodule
